### sv/modexp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, reset constant and sequencer states for the exponentiation
// core and its checker.
// ----------------------------------------------------------------------------
package modexp_pkg;

  // Width of every field on the ports
  localparam int FIELD_WIDTH = 32;

  // Defaults for the top-level parameters
  localparam int OPERAND_WIDTH_DEF  = 32;
  localparam int EXPONENT_WIDTH_DEF = 32;

  // Modulus after reset
  localparam logic [FIELD_WIDTH-1:0] MODULUS_RESET = 32'd1000000007;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL,
    ST_SQR,
    ST_DRAIN
  } state_t;

endpackage
`default_nettype wire

### sv/modular_exponentiation_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular exponentiation core
// Computes base ^ exponent mod modulus by right-to-left square-and-multiply
// on one bit-serial shift-add modular multiplier.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload               Direction
//  -------   ------------------   -------------------   ---------
//  in        in_valid/in_ready    base, exponent        into core
//  out       out_valid/out_ready  power_mod             out of core
//  cfg       cfg_wr_en            cfg_wr_data (modulus) into core
//
//  Work: each item runs the base reduction, then one multiplier run per set
//  exponent bit and one squaring per exponent bit below the highest set
//  bit, and then loads the output register. The single shift-add
//  multiplier takes one multiplier bit per cycle. A zero exponent costs
//  only the base reduction; a zero modulus skips straight to the result (0).
//  Reset: rst clears the sequencer and the output valid and restores the
//  modulus; no memory needs clearing.
//  Stalls: a result waits in the output register; the core takes the next
//  beat meanwhile and holds its own result at the end until the register
//  frees up.
//
// ----------------------------------------------------------------------------
module modular_exponentiation_core #(
  parameter int OPERAND_WIDTH  = modexp_pkg::OPERAND_WIDTH_DEF,
  parameter int EXPONENT_WIDTH = modexp_pkg::EXPONENT_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration
  input  wire logic                              cfg_wr_en,
  input  wire logic [modexp_pkg::FIELD_WIDTH-1:0] cfg_wr_data,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [modexp_pkg::FIELD_WIDTH-1:0] base,
  input  wire logic [modexp_pkg::FIELD_WIDTH-1:0] exponent,
  // output channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [modexp_pkg::FIELD_WIDTH-1:0]     power_mod
);

  localparam int W   = OPERAND_WIDTH;
  localparam int EW  = EXPONENT_WIDTH;
  localparam int CW  = $clog2(W);
  // exponent bits that actually arrive on the port
  localparam int EIN = (EW < modexp_pkg::FIELD_WIDTH) ? EW : modexp_pkg::FIELD_WIDTH;

  // configuration
  logic [W-1:0] modulus;

  // sequencer
  modexp_pkg::state_t state, state_next;

  // exponentiation registers
  logic [W-1:0]  acc;      // running product
  logic [W-1:0]  sq;       // running square
  logic [EW-1:0] e;        // remaining exponent bits

  // shift-add multiplier: r = x * y mod n, one bit of x per cycle, MSB first
  logic [W-1:0]  x_sh;
  logic [W-1:0]  y;
  logic [W-1:0]  r;
  logic [CW-1:0] cnt;

  logic in_fire;
  logic busy;
  logic last;
  logic out_free;

  // multiplier step
  logic [W:0]   n_ext;
  logic [W:0]   dbl;
  logic [W-1:0] dbl_red;
  logic [W:0]   sum;
  logic [W-1:0] red;

  // operands for the next multiplier run
  logic [W-1:0]  sq_new;
  logic [W-1:0]  acc_new;
  logic [EW-1:0] e_new;
  logic [W-1:0]  x_next;
  logic [W-1:0]  y_next;

  assign in_fire  = in_valid && in_ready;
  assign busy     = (state == modexp_pkg::ST_REDUCE) || (state == modexp_pkg::ST_MUL) ||
                    (state == modexp_pkg::ST_SQR);
  assign last     = (cnt == CW'(W - 1));
  assign out_free = !out_valid || out_ready;

  // Double the partial remainder, fold back once, then add y when the
  // current multiplier bit is set and fold back again. r and y stay below
  // n, so a single subtract suffices at each fold.
  always_comb begin
    n_ext   = {1'b0, modulus};
    dbl     = {r, 1'b0};
    dbl_red = (dbl >= n_ext) ? W'(dbl - n_ext) : dbl[W-1:0];
    sum     = {1'b0, dbl_red} + {1'b0, (y & {W{x_sh[W-1]}})};
    red     = (sum >= n_ext) ? W'(sum - n_ext) : sum[W-1:0];
  end

  // Values as they will stand once the current run retires
  always_comb begin
    sq_new  = (state == modexp_pkg::ST_MUL) ? sq : red;
    acc_new = (state == modexp_pkg::ST_MUL) ? red : acc;
    e_new   = (state == modexp_pkg::ST_SQR) ? (e >> 1) : e;
  end

  // Next state and handshake outputs
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      modexp_pkg::ST_IDLE: begin
        // drop ready while reset holds, so no beat gets lost
        in_ready = !rst;
        if (in_valid) begin
          // no reduction possible with a zero modulus: result is zero
          state_next = (modulus == '0) ? modexp_pkg::ST_DRAIN : modexp_pkg::ST_REDUCE;
        end
      end
      modexp_pkg::ST_REDUCE, modexp_pkg::ST_SQR: begin
        if (last) begin
          if (e_new == '0) begin
            state_next = modexp_pkg::ST_DRAIN;
          end else if (e_new[0]) begin
            state_next = modexp_pkg::ST_MUL;
          end else begin
            state_next = modexp_pkg::ST_SQR;
          end
        end
      end
      modexp_pkg::ST_MUL: begin
        if (last) begin
          // skip the final squaring: no higher bit will use it
          state_next = ((e >> 1) != '0) ? modexp_pkg::ST_SQR : modexp_pkg::ST_DRAIN;
        end
      end
      modexp_pkg::ST_DRAIN: begin
        if (out_free) begin
          state_next = modexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = modexp_pkg::ST_IDLE;
      end
    endcase
  end

  // Multiply acc by the square, or square the square
  always_comb begin
    x_next = sq_new;
    y_next = (state_next == modexp_pkg::ST_MUL) ? acc_new : sq_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= modexp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= W'(modexp_pkg::MODULUS_RESET);
    end else if (cfg_wr_en) begin
      modulus <= cfg_wr_data[W-1:0];
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      // reduce the base first: run it through the multiplier against 1
      x_sh <= base[W-1:0];
      y    <= W'(1);
      r    <= '0;
      cnt  <= '0;
      e    <= EW'(exponent[EIN-1:0]);
      acc  <= (modulus == W'(1) || modulus == '0) ? '0 : W'(1);
    end else if (busy) begin
      if (last) begin
        sq   <= sq_new;
        acc  <= acc_new;
        e    <= e_new;
        // load the next run back to back
        r    <= '0;
        cnt  <= '0;
        x_sh <= x_next;
        y    <= y_next;
      end else begin
        r    <= red;
        x_sh <= x_sh << 1;
        cnt  <= cnt + CW'(1);
      end
    end
  end

  // Output register: hold the result until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == modexp_pkg::ST_DRAIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == modexp_pkg::ST_DRAIN && out_free) begin
      power_mod <= modexp_pkg::FIELD_WIDTH'(acc);
    end
  end

endmodule
`default_nettype wire

### sv/modexp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular exponentiation checker
// Port-level properties of the exponentiation core, bound to its top level.
// ----------------------------------------------------------------------------
module modexp_checker #(
  parameter int OPERAND_WIDTH = modexp_pkg::OPERAND_WIDTH_DEF
) (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              cfg_wr_en,
  input wire logic [modexp_pkg::FIELD_WIDTH-1:0] cfg_wr_data,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [modexp_pkg::FIELD_WIDTH-1:0] power_mod
);

  localparam int W = OPERAND_WIDTH;

  // shadow of the modulus as seen on the configuration port
  logic [W-1:0] modulus_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_seen <= W'(modexp_pkg::MODULUS_RESET);
    end else if (cfg_wr_en) begin
      modulus_seen <= cfg_wr_data[W-1:0];
    end
  end

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(power_mod))
    else $error("result beat changed while stalled");

  // one item at a time: the core is busy right after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("core took a beat while busy");

  // an idle core stays ready until a beat arrives
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    in_ready && !in_valid |=> in_ready)
    else $error("idle core dropped ready without a beat");

  // every result lies below the modulus (zero when the modulus is zero)
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((modulus_seen == '0) ? (power_mod == '0) :
                   (power_mod < modexp_pkg::FIELD_WIDTH'(modulus_seen))))
    else $error("result not reduced by the modulus");

endmodule

bind modular_exponentiation_core modexp_checker #(
  .OPERAND_WIDTH(OPERAND_WIDTH)
) u_modexp_checker (
  .clk        (clk),
  .rst        (rst),
  .cfg_wr_en  (cfg_wr_en),
  .cfg_wr_data(cfg_wr_data),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .power_mod  (power_mod)
);
`default_nettype wire
